### sv/vmt_pkg.sv
// Shared types, constants and helpers of the vector matrix transform core.
`timescale 1ns / 1ps
package vmt_pkg;

  localparam int unsigned CFG_REGS  = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

  localparam logic [CFG_W-1:0] ONE_LO = 64'h0000_0000_0001_0000;
  localparam logic [CFG_W-1:0] ONE_HI = 64'h0001_0000_0000_0000;

  localparam int unsigned COL_W     = 50;  // truncated column value
  localparam int unsigned DIV_STEPS = 33;  // quotient bits
  localparam int unsigned DIV_LAT   = DIV_STEPS + 1;

  localparam int unsigned MID_DEPTH_DEF = 4;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } vec_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               divide_by_zero;
    logic               overflow;
  } res_t;

  // Classified item between front and back
  typedef struct packed {
    logic               point;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } work_t;

  // Sideband that travels alongside the dividers
  typedef struct packed {
    logic              valid;
    logic              point;
    logic              dz;
    logic              dir_ov;
    logic [2:0]        neg;
    logic [2:0][31:0]  dir_val;
  } side_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ov;
  } sat_t;

  function automatic logic [CFG_W-1:0] cfg_reset_value(input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_W-1:0] v;
    case (idx)
      REG_ROW0_COLS01: v = ONE_LO;
      REG_ROW1_COLS01: v = ONE_HI;
      REG_ROW2_COLS23: v = ONE_LO;
      REG_ROW3_COLS23: v = ONE_HI;
      default:         v = '0;
    endcase
    return v;
  endfunction

  function automatic sat_t sat32(input logic signed [COL_W-1:0] v);
    sat_t r;
    if (v > $signed(COL_W'(32'sh7FFF_FFFF))) begin
      r.val = 32'h7FFF_FFFF;
      r.ov  = 1'b1;
    end else if (v < $signed({{(COL_W-31){1'b1}}, 31'h0})) begin
      r.val = 32'h8000_0000;
      r.ov  = 1'b1;
    end else begin
      r.val = v[31:0];
      r.ov  = 1'b0;
    end
    return r;
  endfunction

endpackage

### sv/vmt_queue.sv
// Small register queue used between pipeline parts.
`timescale 1ns / 1ps
module vmt_queue import vmt_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = MID_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

### sv/vmt_front.sv
// Input stage: take a transaction and classify it as point or direction.
`timescale 1ns / 1ps
module vmt_front import vmt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  vec_t  vec,
  output logic  full,
  output logic  q_push,
  output work_t q_data,
  input  logic  q_full
);

  logic  valid;
  work_t item;
  logic  ready;

  assign ready  = !valid || !q_full;
  assign full   = !ready;
  assign q_push = valid;
  assign q_data = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && push) begin
      item.point <= !vec.mode;
      item.x     <= vec.in_x;
      item.y     <= vec.in_y;
      item.z     <= vec.in_z;
    end
  end

endmodule

### sv/vmt_div.sv
// Pipelined restoring divider, one quotient bit per stage: floor(mag * 2^16 / den).
`timescale 1ns / 1ps
module vmt_div import vmt_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [COL_W-1:0]     mag,
  input  logic [COL_W-1:0]     den,
  output logic [DIV_STEPS-1:0] quo,
  output logic                 big
);

  logic [COL_W-1:0]     rem  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] low  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q    [DIV_STEPS+1];
  logic [COL_W-1:0]     d    [DIV_STEPS+1];
  logic                 bg   [DIV_STEPS+1];

  // Quotient of 2^DIV_STEPS or more saturates anyway; flag it up front
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= COL_W'(mag[COL_W-1:17]);
      low[0] <= {mag[16:0], 16'h0};
      q[0]   <= '0;
      d[0]   <= den;
      bg[0]  <= ({17'h0, mag} >= {den, 17'h0});
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [COL_W:0] trial;
    logic           ge;
    assign trial = {rem[k-1], low[k-1][DIV_STEPS-1]};
    assign ge    = (trial >= {1'b0, d[k-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? COL_W'(trial - {1'b0, d[k-1]}) : trial[COL_W-1:0];
        low[k] <= {low[k-1][DIV_STEPS-2:0], 1'b0};
        q[k]   <= {q[k-1][DIV_STEPS-2:0], ge};
        d[k]   <= d[k-1];
        bg[k]  <= bg[k-1];
      end
    end
  end

  assign quo = q[DIV_STEPS];
  assign big = bg[DIV_STEPS];

endmodule

### sv/vmt_back.sv
// Execution pipeline: products, column sums, truncation, divide and saturation.
`timescale 1ns / 1ps
module vmt_back import vmt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [3:0][3:0][31:0] mat,
  input  work_t                 item,
  input  logic                  avail,
  output logic                  take,
  output logic                  out_push,
  output res_t                  out_item,
  input  logic                  out_full
);

  logic en;
  logic v1, v2, v3, v4;
  logic pt1, pt2, pt3, pt4;

  logic signed [63:0]      p1 [4][4];
  logic signed [64:0]      a2 [4][2];
  logic signed [65:0]      s3 [4];
  logic signed [COL_W-1:0] c4 [4];

  logic [COL_W-1:0] an5 [3];
  logic [COL_W-1:0] ad5;
  side_t            side [DIV_LAT+1];
  side_t            side5_next;

  logic [DIV_STEPS-1:0] quo [3];
  logic [2:0]           big;
  sat_t                 fin [3];

  assign en   = !out_full;
  assign take = en && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= avail;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Products: one 32x32 multiply per entry, translation row is a shift
  always_ff @(posedge clk) begin
    if (en) begin
      pt1 <= item.point;
      for (int c = 0; c < 4; c++) begin
        p1[c][0] <= $signed(item.x) * $signed(mat[0][c]);
        p1[c][1] <= $signed(item.y) * $signed(mat[1][c]);
        p1[c][2] <= $signed(item.z) * $signed(mat[2][c]);
        p1[c][3] <= item.point ? (64'($signed(mat[3][c])) <<< 16) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt2 <= pt1;
      pt3 <= pt2;
      pt4 <= pt3;
      for (int c = 0; c < 4; c++) begin
        a2[c][0] <= 65'(p1[c][0]) + 65'(p1[c][1]);
        a2[c][1] <= 65'(p1[c][2]) + 65'(p1[c][3]);
        s3[c]    <= 66'(a2[c][0]) + 66'(a2[c][1]);
        // truncate toward zero to Q34.16 (16 fraction bits)
        c4[c]    <= $signed(s3[c][65:16])
                  + $signed(COL_W'(s3[c][65] && (s3[c][15:0] != 16'h0)));
      end
    end
  end

  always_comb begin
    sat_t sx;
    sat_t sy;
    sat_t sz;
    sx = sat32(c4[0]);
    sy = sat32(c4[1]);
    sz = sat32(c4[2]);
    side5_next.valid   = v4;
    side5_next.point   = pt4;
    side5_next.dz      = pt4 && (c4[3] == '0);
    side5_next.dir_ov  = sx.ov || sy.ov || sz.ov;
    side5_next.neg     = {c4[2][COL_W-1] ^ c4[3][COL_W-1],
                          c4[1][COL_W-1] ^ c4[3][COL_W-1],
                          c4[0][COL_W-1] ^ c4[3][COL_W-1]};
    side5_next.dir_val = {sz.val, sy.val, sx.val};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_LAT; k++) begin
        side[k].valid <= 1'b0;
      end
    end else if (en) begin
      side[0] <= side5_next;
      for (int k = 1; k <= DIV_LAT; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        an5[i] <= c4[i][COL_W-1] ? COL_W'(-c4[i]) : COL_W'(c4[i]);
      end
      ad5 <= c4[3][COL_W-1] ? COL_W'(-c4[3]) : COL_W'(c4[3]);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    vmt_div u_div (
      .clk (clk),
      .en  (en),
      .mag (an5[i]),
      .den (ad5),
      .quo (quo[i]),
      .big (big[i])
    );

    always_comb begin
      logic sat;
      logic [DIV_STEPS-1:0] nq;
      nq = -quo[i];
      if (side[DIV_LAT].neg[i]) begin
        sat = big[i] || quo[i][32] || (quo[i][31] && (quo[i][30:0] != '0));
        fin[i].val = sat ? 32'h8000_0000 : nq[31:0];
      end else begin
        sat = big[i] || (quo[i][32:31] != 2'b00);
        fin[i].val = sat ? 32'h7FFF_FFFF : quo[i][31:0];
      end
      fin[i].ov = sat;
    end
  end

  assign out_push = en && side[DIV_LAT].valid;

  always_comb begin
    side_t s;
    s = side[DIV_LAT];
    if (!s.point) begin
      out_item.out_x          = s.dir_val[0];
      out_item.out_y          = s.dir_val[1];
      out_item.out_z          = s.dir_val[2];
      out_item.divide_by_zero = 1'b0;
      out_item.overflow       = s.dir_ov;
    end else if (s.dz) begin
      out_item.out_x          = '0;
      out_item.out_y          = '0;
      out_item.out_z          = '0;
      out_item.divide_by_zero = 1'b1;
      out_item.overflow       = 1'b0;
    end else begin
      out_item.out_x          = fin[0].val;
      out_item.out_y          = fin[1].val;
      out_item.out_z          = fin[2].val;
      out_item.divide_by_zero = 1'b0;
      out_item.overflow       = fin[0].ov || fin[1].ov || fin[2].ov;
    end
  end

endmodule

### sv/vector_matrix_transform_core.sv
// Top level of the homogeneous 4x4 point/direction transform core.
//
//   channel   direction  handshake           payload
//   vec       in         push / full         vec_t: mode, in_x, in_y, in_z
//   res       out        pop / empty         res_t: out_x, out_y, out_z, flags
//   cfg       in         cfg_valid/ready     cfg_index, cfg_data (matrix row halves)
//
// One transaction is accepted per cycle and one result leaves per cycle while no
// queue is full. Latency is set mostly by the 33-stage restoring divider that
// produces one quotient bit per stage for the perspective divide.
// Synchronous reset empties all queues and restores the identity matrix.
// When results are not popped the output queue fills, the back pipeline
// holds, the middle queue fills and full rises; each side stalls on its own.
`timescale 1ns / 1ps
module vector_matrix_transform_core import vmt_pkg::*; #(
  parameter int unsigned MID_DEPTH = MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  vec_t                 vec,
  output logic                 full,
  input  logic                 pop,
  output res_t                 res,
  output logic                 empty,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0]      cfg_regs [CFG_REGS];
  logic [3:0][3:0][31:0] mat;

  logic  mid_push;
  work_t mid_wdata;
  logic  mid_full;
  logic  mid_pop;
  logic  mid_empty;
  logic [$bits(work_t)-1:0] mid_rdata;

  logic out_push;
  res_t out_wdata;
  logic out_full;
  logic [$bits(res_t)-1:0] out_rdata;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_REGS; i++) begin
        cfg_regs[i] <= cfg_reset_value(CFG_IDX_W'(i));
      end
    end else if (cfg_valid) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  // Unpack the matrix: even column in the low half, odd column in the high half
  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign mat[r][c] = cfg_regs[r*2 + c/2][(c%2)*32 +: 32];
    end
  end

  vmt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .vec    (vec),
    .full   (full),
    .q_push (mid_push),
    .q_data (mid_wdata),
    .q_full (mid_full)
  );

  // Decoupling queue between front and back
  vmt_queue #(
    .WIDTH ($bits(work_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  vmt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .mat      (mat),
    .item     (work_t'(mid_rdata)),
    .avail    (!mid_empty),
    .take     (mid_pop),
    .out_push (out_push),
    .out_item (out_wdata),
    .out_full (out_full)
  );

  // Result queue: holds finished transactions until popped
  vmt_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign res = res_t'(out_rdata);

endmodule
